FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the sliding window average.
// Expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

FILE: rtl/swa_pkg.sv
// Shared types and constants of the sliding window average.
// No dependencies.
package swa_pkg;

  localparam int REG_BITS = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } swa_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } swa_div_stat_t;

endpackage

FILE: rtl/swa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/swa_div.sv
// Bit-serial restoring divider: (|sum| << FRAC_BITS) / divisor, one quotient bit per cycle.
// Depends on swa_pkg for the status struct.
module swa_div #(
  parameter int SUM_W     = 22,
  parameter int FRAC_BITS = 8,
  parameter int KW        = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SUM_W-1:0]       sum,
  input  logic [KW-1:0]                 divisor,
  output logic [SUM_W+FRAC_BITS-1:0]    quot,
  output logic                          neg,
  output swa_pkg::swa_div_stat_t        stat
);

  localparam int DIV_W = SUM_W + FRAC_BITS;
  localparam int CW    = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dvd;
  logic [KW-1:0]    rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [SUM_W-1:0] mag;
  logic [KW:0]      trial;
  logic [KW:0]      diff;
  logic             ge;

  assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign trial = {rem, dvd[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= DIV_W'(mag) << FRAC_BITS;
      rem <= '0;
      neg <= sum[SUM_W-1];
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], ge};
      rem <= ge ? diff[KW-1:0] : trial[KW-1:0];
    end
  end

  assign quot = dvd;
  assign stat = {busy, done};

endmodule

FILE: rtl/sliding_window_average.sv
// Sliding window (boxcar) average over a stream of signed samples.
// Uses swa_pkg, swa_ram, swa_div and assert_macros.svh.
//
// Input beats carry one sample in s_axis_tdata and a start flag in s_axis_tuser;
// a set start flag opens a new sequence. The last K samples sit in a ring RAM
// next to their running sum. From the K-th sample of a sequence on, each beat
// yields one output beat: (sum * 2^FRAC_BITS) / K, truncated toward zero.
// Earlier samples of a sequence yield no output beat.
// K is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this. 0 acts as 1,
// values above MAX_WINDOW act as MAX_WINDOW. A write restarts the fill.
// A beat runs READ, ACC, LOAD, then DIV (one quotient bit per cycle) and OUT,
// which fills the output register; a beat that yields no result ends after ACC.
// s_axis_tready is high only between beats. The output register holds a
// result while m_axis_tready is low; a new input beat may be accepted then,
// and its result waits until the register is free.
// Reset (rst, synchronous) sets K to 1 and empties the window.
module sliding_window_average #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_we,
  input  logic [swa_pkg::REG_BITS-1:0]                cfg_wdata,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // [SAMPLE_BITS-1:0] sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]            s_axis_tdata,
  // [0] start_req
  input  logic [0:0]                                  s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // [SAMPLE_BITS+FRAC_BITS-1:0] average
  output logic [((SAMPLE_BITS+FRAC_BITS+7)/8)*8-1:0]  m_axis_tdata
);

  localparam int OUT_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KW     = $clog2(MAX_WINDOW + 1);
  localparam int PW     = KW + 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int DIV_W  = SUM_W + FRAC_BITS;

  swa_pkg::swa_state_t    state;
  swa_pkg::swa_state_t    state_next;
  swa_pkg::swa_div_stat_t div_stat;

  logic [swa_pkg::REG_BITS-1:0] window_size;
  logic [AW-1:0]                write_slot;
  logic [KW-1:0]                fill_count;
  logic signed [SUM_W-1:0]      running_sum;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                         out_valid;
  logic [OUT_W-1:0]             out_data;

  logic [KW-1:0]                k_eff;
  logic [PW-1:0]                oldest_w;
  logic [AW-1:0]                oldest;
  logic [SAMPLE_BITS-1:0]       ram_rdata;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic signed [SUM_W-1:0]      sum_next;
  logic [KW-1:0]                fill_next;
  logic [AW-1:0]                slot_next;
  logic                         fill_full;
  logic                         accept;
  logic                         ram_we;
  logic                         div_start;
  logic                         out_load;
  logic [DIV_W-1:0]             quot;
  logic [DIV_W-1:0]             quot_signed;
  logic                         quot_neg;

  always_comb begin
    priority if (window_size == '0) begin
      k_eff = KW'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(window_size);
    end
  end

  assign oldest_w = (PW'(write_slot) >= PW'(k_eff))
                    ? PW'(write_slot) - PW'(k_eff)
                    : PW'(write_slot) + PW'(MAX_WINDOW) - PW'(k_eff);
  assign oldest   = AW'(oldest_w);

  assign old_sample = ram_rdata;
  assign fill_full  = fill_count >= k_eff;
  assign sum_next   = running_sum + SUM_W'(sample_q)
                      - (fill_full ? SUM_W'(old_sample) : SUM_W'(0));
  assign fill_next  = fill_full ? fill_count : fill_count + 1'b1;
  assign slot_next  = (write_slot == AW'(MAX_WINDOW - 1)) ? '0 : write_slot + 1'b1;
  assign accept     = s_axis_tvalid && s_axis_tready;

  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (sample_q),
    .raddr (oldest),
    .rdata (ram_rdata)
  );

  swa_div #(
    .SUM_W     (SUM_W),
    .FRAC_BITS (FRAC_BITS),
    .KW        (KW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .sum     (running_sum),
    .divisor (k_eff),
    .quot    (quot),
    .neg     (quot_neg),
    .stat    (div_stat)
  );

  assign quot_signed = quot_neg ? -quot : quot;

  always_comb begin
    state_next = state;
    unique case (state)
      swa_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = swa_pkg::ST_READ;
        end
      end
      swa_pkg::ST_READ: state_next = swa_pkg::ST_ACC;
      swa_pkg::ST_ACC: begin
        state_next = (fill_next >= k_eff) ? swa_pkg::ST_LOAD : swa_pkg::ST_IDLE;
      end
      swa_pkg::ST_LOAD: state_next = swa_pkg::ST_DIV;
      swa_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = swa_pkg::ST_OUT;
        end
      end
      swa_pkg::ST_OUT: begin
        if (!out_valid || m_axis_tready) begin
          state_next = swa_pkg::ST_IDLE;
        end
      end
      default: state_next = swa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == swa_pkg::ST_IDLE);
    ram_we        = (state == swa_pkg::ST_ACC);
    div_start     = (state == swa_pkg::ST_LOAD);
    out_load      = (state == swa_pkg::ST_OUT) && (!out_valid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= swa_pkg::ST_IDLE;
      window_size <= swa_pkg::REG_BITS'(1);
      write_slot  <= '0;
      fill_count  <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && s_axis_tuser[0]) begin
        write_slot  <= '0;
        fill_count  <= '0;
        running_sum <= '0;
      end
      if (ram_we) begin
        write_slot  <= slot_next;
        fill_count  <= fill_next;
        running_sum <= sum_next;
      end
      if (cfg_we) begin
        window_size <= cfg_wdata;
        fill_count  <= '0;
        running_sum <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    if (out_load) begin
      out_data <= quot_signed[OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TW'(out_data);

`include "assert_macros.svh"

  `ASSERT_AT(a_fill_bounded, (state == swa_pkg::ST_IDLE) |-> (fill_count <= k_eff))
  `ASSERT_NEVER(a_div_outside_div, div_stat.busy && (state != swa_pkg::ST_DIV))
  `ASSERT_AT(a_busy_after_accept, accept |=> !s_axis_tready)

endmodule
